// ===== sv/lofed_pkg.sv =====
`timescale 1ns / 1ps
package lofed_pkg;

  localparam int unsigned VAL_W  = 64;
  localparam int unsigned VSIZ_W = 31;
  localparam int unsigned IDX_W  = 2;

  typedef enum logic [2:0] {
    ERR_OK         = 3'd0,
    ERR_DOUBLE_ADJ = 3'd1,
    ERR_NOT_MONO   = 3'd2,
    ERR_OFFSET_OVF = 3'd3,
    ERR_LENGTH_OVF = 3'd4
  } err_t;

  typedef enum logic [IDX_W-1:0] {
    REG_NULL_ADJ    = 2'd0,
    REG_FIRST_ITEM  = 2'd1,
    REG_SPARE2      = 2'd2,
    REG_SPARE3      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [VAL_W-1:0] null_adj;
    logic [VAL_W-1:0] first_item;
  } cfg_t;

  // classified row handed from front to back
  typedef struct packed {
    logic [VAL_W-1:0] end_item;
    logic [VAL_W-1:0] end_rel;   // end_item - first_item
    logic             err_adj;
    logic             null_row;
    logic             restart;
    logic             last;
  } row_t;

  typedef struct packed {
    logic [VSIZ_W-1:0] offset;
    logic [VSIZ_W-1:0] length;
    logic              is_null;
    err_t              error;
    logic [VAL_W-1:0]  last_end;
    logic              any_null;
    logic              last_of_batch;
  } res_t;

endpackage

// ===== sv/lofed_fifo.sv =====
`timescale 1ns / 1ps
module lofed_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== sv/lofed_front.sv =====
`timescale 1ns / 1ps
module lofed_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lofed_pkg::cfg_t            cfg,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [lofed_pkg::VAL_W-1:0] in_encoded_end,
  input  logic                       in_restart,
  input  logic                       in_batch_end,
  output logic                       row_push,
  output lofed_pkg::row_t            row,
  input  logic                       row_full
);

  // stage a: null test and adjusted value side by side
  logic                        a_v_r;
  logic [lofed_pkg::VAL_W-1:0] a_enc_r, a_sub_r;
  logic                        a_null_r, a_restart_r, a_last_r;

  // stage b: classified row
  logic            b_v_r;
  lofed_pkg::row_t b_row_r, b_row_nxt;

  logic b_ready, a_ready, a_take;
  logic [lofed_pkg::VAL_W-1:0] end_item;

  assign b_ready  = !b_v_r || !row_full;
  assign a_ready  = !a_v_r || b_ready;
  assign in_full  = !a_ready;
  assign a_take   = in_push && a_ready;
  assign row_push = b_v_r;
  assign row      = b_row_r;

  always_comb begin
    end_item           = a_null_r ? a_sub_r : a_enc_r;
    b_row_nxt.end_item = end_item;
    b_row_nxt.end_rel  = end_item - cfg.first_item;
    b_row_nxt.err_adj  = !(end_item < cfg.null_adj);
    b_row_nxt.null_row = a_null_r;
    b_row_nxt.restart  = a_restart_r;
    b_row_nxt.last     = a_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_v_r <= in_push;
      end
      if (b_ready) begin
        b_v_r <= a_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) begin
      a_enc_r     <= in_encoded_end;
      a_sub_r     <= in_encoded_end - cfg.null_adj;
      a_null_r    <= (in_encoded_end >= cfg.null_adj);
      a_restart_r <= in_restart;
      a_last_r    <= in_batch_end;
    end
    if (b_ready && a_v_r) begin
      b_row_r <= b_row_nxt;
    end
  end

endmodule

// ===== sv/lofed_back.sv =====
`timescale 1ns / 1ps
module lofed_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lofed_pkg::cfg_t             cfg,
  input  logic                        first_wr,
  input  logic [lofed_pkg::VAL_W-1:0] first_wdata,
  input  logic                        row_empty,
  input  lofed_pkg::row_t             row,
  output logic                        row_pop,
  output logic                        res_push,
  output lofed_pkg::res_t             res,
  input  logic                        res_full
);

  localparam int unsigned W  = lofed_pkg::VAL_W;
  localparam int unsigned VW = lofed_pkg::VSIZ_W;

  logic [W-1:0] prev_r, prev_nxt;
  logic [W-1:0] rel_r, rel_nxt;   // prev_r - first_item
  logic         seen_r, seen_nxt;

  logic [W-1:0] eff_prev, eff_rel;
  logic         eff_seen;
  logic [W:0]   diff;
  lofed_pkg::err_t err;
  logic         fire;

  assign fire     = !row_empty && !res_full;
  assign row_pop  = fire;
  assign res_push = fire;

  always_comb begin
    eff_prev = row.restart ? cfg.first_item : prev_r;
    eff_rel  = row.restart ? '0 : rel_r;
    eff_seen = row.restart ? 1'b0 : seen_r;
    diff     = {1'b0, row.end_item} - {1'b0, eff_prev};

    if (row.err_adj) begin
      err = lofed_pkg::ERR_DOUBLE_ADJ;
    end else if (diff[W]) begin
      err = lofed_pkg::ERR_NOT_MONO;
    end else if (|eff_rel[W-1:VW]) begin
      err = lofed_pkg::ERR_OFFSET_OVF;
    end else if (|diff[W-1:VW]) begin
      err = lofed_pkg::ERR_LENGTH_OVF;
    end else begin
      err = lofed_pkg::ERR_OK;
    end

    prev_nxt = prev_r;
    rel_nxt  = rel_r;
    seen_nxt = seen_r;
    if (fire) begin
      if (err == lofed_pkg::ERR_OK) begin
        prev_nxt = row.end_item;
        rel_nxt  = row.end_rel;
        seen_nxt = eff_seen || row.null_row;
      end else begin
        prev_nxt = eff_prev;
        rel_nxt  = eff_rel;
        seen_nxt = eff_seen;
      end
    end else if (first_wr) begin
      rel_nxt = prev_r - first_wdata;
    end

    res.error         = err;
    res.offset        = (err == lofed_pkg::ERR_OK) ? eff_rel[VW-1:0] : '0;
    res.length        = (err == lofed_pkg::ERR_OK) ? diff[VW-1:0] : '0;
    res.is_null       = (err == lofed_pkg::ERR_OK) && row.null_row;
    res.last_end      = prev_nxt;
    res.any_null      = seen_nxt;
    res.last_of_batch = row.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      rel_r  <= '0;
      seen_r <= 1'b0;
    end else begin
      prev_r <= prev_nxt;
      rel_r  <= rel_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

// ===== sv/list_offset_end_decoder_top.sv =====
`timescale 1ns / 1ps
// List end decoder. Each transaction carries one 64-bit encoded list end; the
// block returns its offset from first_item, its length, null flag, error code,
// the running last end and the sticky null flag, one result per row, in order.
// Sustained rate is one row per cycle while the result queue is popped. The
// edge that accepts a row loads the first front classify stage; the row then
// passes through the second front stage, the row queue and the result queue,
// whose head drives the result ports (the decode step that updates the running
// end writes the result queue directly). The running-end register loop in the
// back stage sets the one-row-per-cycle figure. QUEUE_DEPTH sets the depth of
// both the row queue and the result queue. The user must write registers only
// while no row is in flight; the block itself does not enforce this.
module list_offset_end_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lofed_pkg::IDX_W-1:0]   cfg_index,
  input  logic [lofed_pkg::VAL_W-1:0]   cfg_data,
  input  logic                          push,
  output logic                          full,
  input  logic [lofed_pkg::VAL_W-1:0]   in_encoded_end,
  input  logic                          in_restart,
  input  logic                          in_batch_end,
  output logic                          empty,
  input  logic                          pop,
  output logic [lofed_pkg::VSIZ_W-1:0]  out_offset,
  output logic [lofed_pkg::VSIZ_W-1:0]  out_length,
  output logic                          out_is_null,
  output logic [2:0]                    out_error,
  output logic [lofed_pkg::VAL_W-1:0]   out_last_end,
  output logic                          out_any_null,
  output logic                          out_last_of_batch
);

  lofed_pkg::cfg_t cfg_r, cfg_nxt;
  logic            cfg_we, first_wr;

  lofed_pkg::row_t row_in, row_out;
  logic            row_push, row_full, row_pop, row_empty;
  lofed_pkg::res_t res_in, res_out;
  logic            res_push, res_full;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign first_wr  = cfg_we && (cfg_index == lofed_pkg::REG_FIRST_ITEM);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (lofed_pkg::reg_idx_t'(cfg_index))
        lofed_pkg::REG_NULL_ADJ:   cfg_nxt.null_adj   = cfg_data;
        lofed_pkg::REG_FIRST_ITEM: cfg_nxt.first_item = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.null_adj   <= {1'b1, {(lofed_pkg::VAL_W-1){1'b0}}};
      cfg_r.first_item <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lofed_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_push        (push),
    .in_full        (full),
    .in_encoded_end (in_encoded_end),
    .in_restart     (in_restart),
    .in_batch_end   (in_batch_end),
    .row_push       (row_push),
    .row            (row_in),
    .row_full       (row_full)
  );

  lofed_fifo #(
    .WIDTH ($bits(lofed_pkg::row_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_row_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (row_push),
    .wdata (row_in),
    .full  (row_full),
    .pop   (row_pop),
    .rdata (row_out),
    .empty (row_empty)
  );

  lofed_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .first_wr    (first_wr),
    .first_wdata (cfg_data),
    .row_empty   (row_empty),
    .row         (row_out),
    .row_pop     (row_pop),
    .res_push    (res_push),
    .res         (res_in),
    .res_full    (res_full)
  );

  lofed_fifo #(
    .WIDTH ($bits(lofed_pkg::res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign out_offset        = res_out.offset;
  assign out_length        = res_out.length;
  assign out_is_null       = res_out.is_null;
  assign out_error         = res_out.error;
  assign out_last_end      = res_out.last_end;
  assign out_any_null      = res_out.any_null;
  assign out_last_of_batch = res_out.last_of_batch;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam logic [lofed_pkg::VAL_W-1:0] SIZE_MAX = 64'h0000_0000_7fff_ffff;
  localparam logic [lofed_pkg::VAL_W-1:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lofed_pkg::IDX_W-1:0] cfg_index = lofed_pkg::REG_NULL_ADJ;
  logic [lofed_pkg::VAL_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic [lofed_pkg::VAL_W-1:0] in_encoded_end = '0;
  logic in_restart = 1'b0;
  logic in_batch_end = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [lofed_pkg::VSIZ_W-1:0] out_offset;
  logic [lofed_pkg::VSIZ_W-1:0] out_length;
  logic out_is_null;
  logic [2:0] out_error;
  logic [lofed_pkg::VAL_W-1:0] out_last_end;
  logic out_any_null;
  logic out_last_of_batch;

  // decoder state mirror
  logic [lofed_pkg::VAL_W-1:0] adj_reg = 64'h8000_0000_0000_0000;
  logic [lofed_pkg::VAL_W-1:0] first_reg = '0;
  logic [lofed_pkg::VAL_W-1:0] run_end = '0;
  logic nulls_flag = 1'b0;
  lofed_pkg::res_t pending_rows[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;

  always #2 clk = ~clk;

  list_offset_end_decoder_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full),
    .in_encoded_end(in_encoded_end), .in_restart(in_restart), .in_batch_end(in_batch_end),
    .empty(empty), .pop(pop),
    .out_offset(out_offset), .out_length(out_length), .out_is_null(out_is_null),
    .out_error(out_error), .out_last_end(out_last_end), .out_any_null(out_any_null),
    .out_last_of_batch(out_last_of_batch)
  );

  function automatic void decode_row(logic [lofed_pkg::VAL_W-1:0] enc, logic rs, logic be);
    lofed_pkg::res_t r;
    logic [lofed_pkg::VAL_W-1:0] end_v;
    logic [lofed_pkg::VAL_W-1:0] rel;
    logic [lofed_pkg::VAL_W-1:0] len;
    logic nrow;
    lofed_pkg::err_t e;
    if (rs) begin
      run_end = first_reg;
      nulls_flag = 1'b0;
    end
    nrow = (enc >= adj_reg);
    end_v = nrow ? enc - adj_reg : enc;
    rel = run_end - first_reg;
    len = end_v - run_end;
    if (!(end_v < adj_reg)) e = lofed_pkg::ERR_DOUBLE_ADJ;
    else if (run_end > end_v) e = lofed_pkg::ERR_NOT_MONO;
    else if (rel > SIZE_MAX) e = lofed_pkg::ERR_OFFSET_OVF;
    else if (len > SIZE_MAX) e = lofed_pkg::ERR_LENGTH_OVF;
    else e = lofed_pkg::ERR_OK;
    if (e == lofed_pkg::ERR_OK) begin
      r.offset = rel[lofed_pkg::VSIZ_W-1:0];
      r.length = len[lofed_pkg::VSIZ_W-1:0];
      r.is_null = nrow;
      if (nrow) nulls_flag = 1'b1;
      run_end = end_v;
    end else begin
      r.offset = '0;
      r.length = '0;
      r.is_null = 1'b0;
    end
    r.error = e;
    r.last_end = run_end;
    r.any_null = nulls_flag;
    r.last_of_batch = be;
    pending_rows.push_back(r);
  endfunction

  // result checking and pop driving
  always @(posedge clk) begin
    lofed_pkg::res_t got;
    lofed_pkg::res_t exp;
    logic bad;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got.offset = out_offset;
        got.length = out_length;
        got.is_null = out_is_null;
        got.error = lofed_pkg::err_t'(out_error);
        got.last_end = out_last_end;
        got.any_null = out_any_null;
        got.last_of_batch = out_last_of_batch;
        if (pending_rows.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transaction: off=%0d len=%0d err=%0d last_end=%h",
                     got.offset, got.length, got.error, got.last_end);
        end else begin
          exp = pending_rows.pop_front();
          bad = (got.offset !== exp.offset) || (got.length !== exp.length) ||
                (got.is_null !== exp.is_null) || (got.error !== exp.error) ||
                (got.last_end !== exp.last_end) || (got.any_null !== exp.any_null) ||
                (got.last_of_batch !== exp.last_of_batch);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch exp: off=%0d len=%0d null=%0d err=%0d end=%h any=%0d last=%0d",
                       exp.offset, exp.length, exp.is_null, exp.error, exp.last_end,
                       exp.any_null, exp.last_of_batch);
              $display("         got: off=%0d len=%0d null=%0d err=%0d end=%h any=%0d last=%0d",
                       got.offset, got.length, got.is_null, got.error, got.last_end,
                       got.any_null, got.last_of_batch);
            end
          end
        end
      end
      if (hold_req != 0) begin
        stall_cycles = hold_req;
        hold_req = 0;
      end
      if (stall_cycles != 0) begin
        stall_cycles--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    int unsigned quiet;
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end else begin
      quiet = 0;
    end
  end

  task automatic send_row(input logic [lofed_pkg::VAL_W-1:0] enc, input logic rs,
                          input logic be);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_encoded_end <= enc;
    in_restart <= rs;
    in_batch_end <= be;
    @(posedge clk);
    while (full) @(posedge clk);
    decode_row(enc, rs, be);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pending_rows.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input lofed_pkg::reg_idx_t idx,
                           input logic [lofed_pkg::VAL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      lofed_pkg::REG_NULL_ADJ: adj_reg = val;
      lofed_pkg::REG_FIRST_ITEM: first_reg = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [lofed_pkg::VAL_W-1:0] adj,
                           input logic [lofed_pkg::VAL_W-1:0] first);
    wait_drained();
    write_reg(lofed_pkg::REG_NULL_ADJ, adj);
    write_reg(lofed_pkg::REG_FIRST_ITEM, first);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_rows(input int unsigned count);
    int unsigned left;
    int unsigned pick;
    logic rs;
    logic be;
    logic [lofed_pkg::VAL_W-1:0] base;
    logic [lofed_pkg::VAL_W-1:0] len;
    logic [lofed_pkg::VAL_W-1:0] enc;
    left = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (left == 0) begin
        left = $urandom_range(1, 12);
        rs = ($urandom_range(19) != 0);
      end else begin
        rs = ($urandom_range(49) == 0);
      end
      base = rs ? first_reg : run_end;
      pick = $urandom_range(99);
      if (pick < 8) begin
        enc = {$urandom, $urandom};
      end else if (pick < 12) begin
        enc = base - 64'($urandom_range(1, 100));
      end else begin
        pick = $urandom_range(99);
        if (pick < 85) len = 64'($urandom_range(0, 40));
        else if (pick < 95) len = 64'($urandom_range(0, 32'h7fff_ffff));
        else len = 64'h8000_0000 + 64'($urandom_range(0, 3));
        enc = base + len;
        if ($urandom_range(3) == 0) enc = enc + adj_reg;
      end
      be = (left == 1);
      left--;
      send_row(enc, rs, be);
    end
  endtask

  task automatic test_directed();
    // reset settings, no restart yet
    send_row(64'd0, 1'b0, 1'b0);
    send_row(64'd5, 1'b0, 1'b0);
    send_row(64'd3, 1'b0, 1'b0);
    send_row(64'h8000_0000_0000_000a, 1'b0, 1'b0);
    send_row(ALL_ONES, 1'b0, 1'b0);
    send_row(64'd10 + SIZE_MAX, 1'b0, 1'b0);
    send_row(64'd11 + SIZE_MAX, 1'b0, 1'b1);
    send_row(64'd7, 1'b1, 1'b0);
    send_row(64'h8000_0000_0000_0000, 1'b0, 1'b1);
    // zero adjustment: everything is double adjusted
    configure(64'd0, 64'd0);
    send_row(64'd0, 1'b1, 1'b0);
    send_row(ALL_ONES, 1'b0, 1'b1);
    // largest adjustment, first item one below it
    configure(ALL_ONES, ALL_ONES - 1);
    send_row(ALL_ONES - 1, 1'b1, 1'b0);
    send_row(ALL_ONES, 1'b0, 1'b1);
    // smallest nonzero adjustment
    configure(64'd1, 64'd0);
    send_row(64'd0, 1'b1, 1'b0);
    send_row(64'd1, 1'b0, 1'b0);
    send_row(64'd2, 1'b0, 1'b1);
    // first item above adjustment, offset wraps without restart
    configure(64'd100, 64'd200);
    send_row(64'd50, 1'b0, 1'b0);
    send_row(64'd250, 1'b1, 1'b0);
    send_row(64'd50, 1'b0, 1'b1);
  endtask

  task automatic test_random_phase(input int unsigned s_pct, input int unsigned r_pct);
    logic [lofed_pkg::VAL_W-1:0] adj;
    logic [lofed_pkg::VAL_W-1:0] first;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int unsigned k = 0; k < 3; k++) begin
      case (k)
        0: begin
          adj = 64'h8000_0000_0000_0000;
          first = {2'b00, 30'($urandom_range(0, 32'h3fff_ffff)), $urandom};
        end
        1: begin
          adj = {2'b10, 30'($urandom_range(0, 32'h3fff_ffff)), $urandom};
          first = {3'b000, 29'($urandom_range(0, 32'h1fff_ffff)), $urandom};
        end
        default: begin
          adj = 64'd5000 + 64'($urandom_range(0, 3000));
          first = 64'($urandom_range(0, 1000));
        end
      endcase
      configure(adj, first);
      random_rows(120);
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    hold_req = 300;
    random_rows(40);
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 36;
    recv_idle_pct = 77;
    test_directed();
    test_random_phase(36, 77);
    test_random_phase(77, 36);
    test_random_phase(0, 0);
    test_backpressure();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/lofed_pkg.sv
sv/lofed_fifo.sv
sv/lofed_front.sv
sv/lofed_back.sv
sv/list_offset_end_decoder_top.sv
test/tb.sv
